[design/wcsg_pkg.sv]
`timescale 1ns / 1ps
// Shared types, codes and arithmetic helpers of the wire circle segment generator.
// Used by every module of the block; depends on nothing else.
package wcsg_pkg;

    localparam int S_DATA_W = 256;
    localparam int S_USER_W = 4;
    localparam int M_DATA_W = 272;
    localparam int M_USER_W = 1;

    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = 1;
    localparam int Q_CNT_W = 2;

    localparam int PROD_W = 47;
    localparam logic [PROD_W-1:0] ROUND_HALF = 47'd16384;

    localparam logic [1:0] KIND_LINE   = 2'd0;
    localparam logic [1:0] KIND_CIRCLE = 2'd1;
    localparam logic [1:0] KIND_REPORT = 2'd2;

    localparam logic [1:0] PLANE_XY   = 2'd0;
    localparam logic [1:0] PLANE_XZ   = 2'd1;
    localparam logic [1:0] PLANE_YZ   = 2'd2;
    localparam logic [1:0] PLANE_NONE = 2'd3;

    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    typedef enum logic [1:0] {
        OP_LINE,
        OP_CIRCLE,
        OP_REPORT
    } op_t;

    typedef struct packed {
        op_t              op;
        logic [1:0]       ia;
        logic [1:0]       ib;
        logic [2:0][31:0] a;
        logic [2:0][31:0] b;
        logic [30:0]      radius;
        logic [31:0]      rgba;
    } cmd_t;

    // Magnitude of the Q1.15 cosine table entry.
    function automatic logic [15:0] cos_mag(input logic [4:0] idx);
        logic [15:0] m;
        case (idx[3:0])
            4'd0:    m = 16'd32768;
            4'd1:    m = 16'd32138;
            4'd2:    m = 16'd30274;
            4'd3:    m = 16'd27246;
            4'd4:    m = 16'd23170;
            4'd5:    m = 16'd18205;
            4'd6:    m = 16'd12540;
            4'd7:    m = 16'd6393;
            4'd8:    m = 16'd0;
            4'd9:    m = 16'd6393;
            4'd10:   m = 16'd12540;
            4'd11:   m = 16'd18205;
            4'd12:   m = 16'd23170;
            4'd13:   m = 16'd27246;
            4'd14:   m = 16'd30274;
            default: m = 16'd32138;
        endcase
        return m;
    endfunction

    // Sign of the cosine table entry; entries with zero magnitude count as positive.
    function automatic logic cos_neg(input logic [4:0] idx);
        return (idx > 5'd8) && (idx < 5'd24);
    endfunction

    // Center plus or minus a magnitude, saturated to the signed 32-bit range.
    function automatic logic [31:0] add_sat(input logic [31:0] center,
                                            input logic [30:0] mag,
                                            input logic neg);
        logic signed [33:0] c;
        logic signed [33:0] t;
        logic signed [33:0] s;
        logic [31:0]        r;
        c = 34'(signed'(center));
        t = signed'({3'b000, mag});
        s = neg ? (c - t) : (c + t);
        if (s > 34'sd2147483647) begin
            r = 32'h7FFF_FFFF;
        end else if (s < -34'sd2147483648) begin
            r = 32'h8000_0000;
        end else begin
            r = s[31:0];
        end
        return r;
    endfunction

endpackage

[design/wire_circle_segment_generator.sv]
`timescale 1ns / 1ps
// The segment engine handles a line word or a report word in its accept step alone; a circle word
// goes through accept, setup, then one chord a cycle for CIRCLE_SEGMENTS chords, while the output
// keeps up. The chord rate is set by the pair of radius-by-table multipliers, which are
// registered and shared by all chords of a circle. Input words pass a register stage and a two-entry
// queue, so the input side can go on accepting while a circle is being drawn, until both are full.
// Top level of the wire circle segment generator; depends on wcsg_pkg, wcsg_front,
// wcsg_queue and wcsg_back.
module wire_circle_segment_generator
#(
    parameter int MAX_VERTICES    = 8192,
    parameter int CIRCLE_SEGMENTS = 32
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [wcsg_pkg::S_DATA_W-1:0] s_tdata,  // ax, ay, az, bx, by, bz, radius, rgba, pad
    input  logic [wcsg_pkg::S_USER_W-1:0] s_tuser,  // kind, plane
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // p0x, p0y, p0z, p1x, p1y, p1z, seg_color, drawn_lines, dropped_lines, pad
    output logic [wcsg_pkg::M_DATA_W-1:0] m_tdata,
    output logic [wcsg_pkg::M_USER_W-1:0] m_tuser,  // report
    output logic                          m_tlast
);

    logic           front_valid;
    logic           front_ready;
    wcsg_pkg::cmd_t front_cmd;
    logic           queue_valid;
    logic           queue_ready;
    wcsg_pkg::cmd_t queue_cmd;

    wcsg_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cmd_valid (front_valid),
        .cmd_ready (front_ready),
        .cmd       (front_cmd)
    );

    wcsg_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (front_valid),
        .in_ready  (front_ready),
        .in_cmd    (front_cmd),
        .out_valid (queue_valid),
        .out_ready (queue_ready),
        .out_cmd   (queue_cmd)
    );

    wcsg_back
    #(
        .MAX_VERTICES    (MAX_VERTICES),
        .CIRCLE_SEGMENTS (CIRCLE_SEGMENTS)
    )
    u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (queue_valid),
        .cmd_ready (queue_ready),
        .cmd       (queue_cmd),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

[design/wcsg_front.sv]
`timescale 1ns / 1ps
// Input side: accepts words, sorts them by kind and plane, and registers a command.
// Words of no known kind and circle words with no plane are dropped. Depends on wcsg_pkg.
module wcsg_front
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [wcsg_pkg::S_DATA_W-1:0] s_tdata,  // ax, ay, az, bx, by, bz, radius, rgba, pad
    input  logic [wcsg_pkg::S_USER_W-1:0] s_tuser,  // kind, plane
    output logic                          cmd_valid,
    input  logic                          cmd_ready,
    output wcsg_pkg::cmd_t                cmd
);

    logic           hold_valid_reg;
    logic           hold_valid_next;
    wcsg_pkg::cmd_t cmd_reg;
    wcsg_pkg::cmd_t cmd_next;
    logic           keep;
    logic           accept;
    logic [1:0]     kind;
    logic [1:0]     plane;

    assign kind   = s_tuser[1:0];
    assign plane  = s_tuser[3:2];
    assign accept = s_tvalid && s_tready;

    always_comb
    begin
        cmd_next.a[0]   = s_tdata[31:0];
        cmd_next.a[1]   = s_tdata[63:32];
        cmd_next.a[2]   = s_tdata[95:64];
        cmd_next.b[0]   = s_tdata[127:96];
        cmd_next.b[1]   = s_tdata[159:128];
        cmd_next.b[2]   = s_tdata[191:160];
        cmd_next.radius = s_tdata[222:192];
        cmd_next.rgba   = s_tdata[254:223];
        cmd_next.ia     = (plane == wcsg_pkg::PLANE_YZ) ? wcsg_pkg::AXIS_Y : wcsg_pkg::AXIS_X;
        cmd_next.ib     = (plane == wcsg_pkg::PLANE_XY) ? wcsg_pkg::AXIS_Y : wcsg_pkg::AXIS_Z;
        cmd_next.op     = wcsg_pkg::OP_LINE;
        keep            = 1'b0;
        unique case (kind)
            wcsg_pkg::KIND_LINE:
            begin
                cmd_next.op = wcsg_pkg::OP_LINE;
                keep        = 1'b1;
            end
            wcsg_pkg::KIND_CIRCLE:
            begin
                cmd_next.op = wcsg_pkg::OP_CIRCLE;
                keep        = (plane != wcsg_pkg::PLANE_NONE);
            end
            wcsg_pkg::KIND_REPORT:
            begin
                cmd_next.op = wcsg_pkg::OP_REPORT;
                keep        = 1'b1;
            end
            default:
            begin
                keep = 1'b0;
            end
        endcase
    end

    assign s_tready        = !hold_valid_reg || cmd_ready;
    assign hold_valid_next = (accept && keep) || (hold_valid_reg && !cmd_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= cmd_next;
        end
    end

    assign cmd_valid = hold_valid_reg;
    assign cmd       = cmd_reg;

endmodule

[design/wcsg_queue.sv]
`timescale 1ns / 1ps
// Two-entry command queue between the input side and the segment engine.
// Depends on wcsg_pkg.
module wcsg_queue
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  wcsg_pkg::cmd_t in_cmd,
    output logic           out_valid,
    input  logic           out_ready,
    output wcsg_pkg::cmd_t out_cmd
);

    wcsg_pkg::cmd_t                 slot_reg [wcsg_pkg::Q_DEPTH];
    logic [wcsg_pkg::Q_PTR_W-1:0]   wr_ptr_reg;
    logic [wcsg_pkg::Q_PTR_W-1:0]   rd_ptr_reg;
    logic [wcsg_pkg::Q_CNT_W-1:0]   count_reg;
    logic [wcsg_pkg::Q_CNT_W-1:0]   count_next;
    logic                           push;
    logic                           pop;

    assign in_ready  = (count_reg != wcsg_pkg::Q_CNT_W'(wcsg_pkg::Q_DEPTH));
    assign out_valid = (count_reg != '0);
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;
    assign out_cmd   = slot_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= in_cmd;
        end
    end

    property p_no_overflow;
        @(posedge clk) disable iff (!rst_n)
        count_reg <= wcsg_pkg::Q_CNT_W'(wcsg_pkg::Q_DEPTH);
    endproperty
    a_no_overflow: assert property (p_no_overflow)
        else $error("Command queue holds more entries than it has.");

    property p_pop_count;
        @(posedge clk) disable iff (!rst_n)
        (pop && !push) |=> (count_reg == $past(count_reg) - 1'b1);
    endproperty
    a_pop_count: assert property (p_pop_count)
        else $error("Command queue count did not drop after a read.");

    property p_ptr_gap;
        @(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (wr_ptr_reg == rd_ptr_reg);
    endproperty
    a_ptr_gap: assert property (p_ptr_gap)
        else $error("Empty command queue with pointers apart.");

endmodule

[design/wcsg_back.sv]
`timescale 1ns / 1ps
// Segment engine: vertex budget, circle chord sequencer and output register.
// Depends on wcsg_pkg.
module wcsg_back
#(
    parameter int MAX_VERTICES    = 8192,
    parameter int CIRCLE_SEGMENTS = 32
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cmd_valid,
    output logic                          cmd_ready,
    input  wcsg_pkg::cmd_t                cmd,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [wcsg_pkg::M_DATA_W-1:0] m_tdata,
    output logic [wcsg_pkg::M_USER_W-1:0] m_tuser,
    output logic                          m_tlast
);

    localparam int UW  = $clog2(MAX_VERTICES + 1);
    localparam int UWX = (UW > 14) ? UW : 14;
    localparam int KW  = $clog2(CIRCLE_SEGMENTS + 1);
    localparam int RW  = $clog2(CIRCLE_SEGMENTS);
    localparam logic [UW+1:0]  MAX_V  = (UW + 2)'(MAX_VERTICES);
    localparam logic [KW-1:0]  K_LAST = KW'(CIRCLE_SEGMENTS);
    localparam logic [4:0]     Q0_V   = 5'(32 / CIRCLE_SEGMENTS);
    localparam logic [RW:0]    R0_V   = (RW + 1)'(32 % CIRCLE_SEGMENTS);
    localparam logic [RW:0]    N_V    = (RW + 1)'(CIRCLE_SEGMENTS);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SETUP,
        S_CHORD
    } state_t;

    state_t                        state_reg;
    wcsg_pkg::cmd_t                cmd_reg;
    logic [KW-1:0]                 k_reg;
    logic [4:0]                    idx_reg;
    logic [4:0]                    idx_next;
    logic [RW-1:0]                 rem_reg;
    logic [RW-1:0]                 rem_next;
    logic [wcsg_pkg::PROD_W-1:0]   prod_c_reg;
    logic [wcsg_pkg::PROD_W-1:0]   prod_s_reg;
    logic                          neg_c_reg;
    logic                          neg_s_reg;
    logic [2:0][31:0]              prev_reg;
    logic [UW-1:0]                 used_reg;
    logic [31:0]                   dropped_reg;
    logic                          out_valid_reg;
    logic                          out_report_reg;
    logic [2:0][31:0]              out_p0_reg;
    logic [2:0][31:0]              out_p1_reg;
    logic [31:0]                   out_color_reg;
    logic [12:0]                   out_drawn_reg;
    logic [31:0]                   out_dropped_reg;
    logic                          out_last_reg;

    logic                          out_free;
    logic                          fit;
    logic                          fit_two;
    logic [UW-1:0]                 used_plus2;
    logic [31:0]                   dropped_plus2;
    logic [UWX-1:0]                used_x;
    logic [RW:0]                   rem_sum;
    logic                          rem_wrap;
    logic [4:0]                    idx_mul;
    logic [4:0]                    idx_mul_s;
    logic [wcsg_pkg::PROD_W-1:0]   rnd_c;
    logic [wcsg_pkg::PROD_W-1:0]   rnd_s;
    logic [31:0]                   sum_c;
    logic [31:0]                   sum_s;
    logic [2:0][31:0]              cur;
    logic [2:0][31:0]              setup_prev;
    logic                          accept;
    logic                          step;
    logic                          emit;

    assign out_free      = !out_valid_reg || m_tready;
    assign cmd_ready     = (state_reg == S_IDLE) && out_free;
    assign accept        = cmd_valid && cmd_ready;
    assign step          = (state_reg == S_CHORD) && out_free;
    assign fit           = (({2'b00, used_reg} + (UW + 2)'(2)) <= MAX_V);
    assign fit_two       = (({2'b00, used_reg} + (UW + 2)'(4)) <= MAX_V);
    assign used_plus2    = used_reg + UW'(2);
    assign dropped_plus2 = (dropped_reg <= 32'hFFFF_FFFD) ? (dropped_reg + 32'd2)
                                                          : 32'hFFFF_FFFF;
    assign used_x        = UWX'(used_reg);
    assign emit          = (accept && (((cmd.op == wcsg_pkg::OP_LINE) && fit)
                                       || (cmd.op == wcsg_pkg::OP_REPORT)))
                           || (step && fit);

    // Angle index of the next point, advanced by a fractional step of 32/N.
    assign rem_sum  = {1'b0, rem_reg} + R0_V;
    assign rem_wrap = (rem_sum >= N_V);
    assign rem_next = rem_wrap ? RW'(rem_sum - N_V) : RW'(rem_sum);
    assign idx_next = idx_reg + Q0_V + {4'b0000, rem_wrap};

    assign idx_mul   = (state_reg == S_SETUP) ? idx_reg : idx_next;
    assign idx_mul_s = idx_mul + 5'd24;

    assign rnd_c = prod_c_reg + wcsg_pkg::ROUND_HALF;
    assign rnd_s = prod_s_reg + wcsg_pkg::ROUND_HALF;
    assign sum_c = wcsg_pkg::add_sat(cmd_reg.a[cmd_reg.ia], rnd_c[45:15], neg_c_reg);
    assign sum_s = wcsg_pkg::add_sat(cmd_reg.a[cmd_reg.ib], rnd_s[45:15], neg_s_reg);

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (cmd_reg.ia == 2'(i))
            begin
                cur[i]        = sum_c;
                setup_prev[i] = wcsg_pkg::add_sat(cmd_reg.a[i], cmd_reg.radius, 1'b0);
            end
            else if (cmd_reg.ib == 2'(i))
            begin
                cur[i]        = sum_s;
                setup_prev[i] = cmd_reg.a[i];
            end
            else
            begin
                cur[i]        = cmd_reg.a[i];
                setup_prev[i] = cmd_reg.a[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            used_reg      <= '0;
            dropped_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        cmd_reg <= cmd;
                        case (cmd.op)
                            wcsg_pkg::OP_LINE:
                            begin
                                if (fit)
                                begin
                                    used_reg        <= used_plus2;
                                    out_report_reg  <= 1'b0;
                                    out_p0_reg      <= cmd.a;
                                    out_p1_reg      <= cmd.b;
                                    out_color_reg   <= cmd.rgba;
                                    out_drawn_reg   <= '0;
                                    out_dropped_reg <= '0;
                                    out_last_reg    <= 1'b1;
                                end
                                else
                                begin
                                    dropped_reg <= dropped_plus2;
                                end
                            end
                            wcsg_pkg::OP_CIRCLE:
                            begin
                                k_reg     <= KW'(1);
                                idx_reg   <= Q0_V;
                                rem_reg   <= R0_V[RW-1:0];
                                state_reg <= S_SETUP;
                            end
                            wcsg_pkg::OP_REPORT:
                            begin
                                used_reg        <= '0;
                                dropped_reg     <= '0;
                                out_report_reg  <= 1'b1;
                                out_p0_reg      <= '0;
                                out_p1_reg      <= '0;
                                out_color_reg   <= '0;
                                out_drawn_reg   <= used_x[13:1];
                                out_dropped_reg <= {1'b0, dropped_reg[31:1]};
                                out_last_reg    <= 1'b1;
                            end
                            default:
                            begin
                                state_reg <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_SETUP:
                begin
                    prev_reg   <= setup_prev;
                    prod_c_reg <= wcsg_pkg::PROD_W'(cmd_reg.radius)
                                * wcsg_pkg::PROD_W'(wcsg_pkg::cos_mag(idx_mul));
                    prod_s_reg <= wcsg_pkg::PROD_W'(cmd_reg.radius)
                                * wcsg_pkg::PROD_W'(wcsg_pkg::cos_mag(idx_mul_s));
                    neg_c_reg  <= wcsg_pkg::cos_neg(idx_mul);
                    neg_s_reg  <= wcsg_pkg::cos_neg(idx_mul_s);
                    state_reg  <= S_CHORD;
                end
                S_CHORD:
                begin
                    if (step)
                    begin
                        if (fit)
                        begin
                            used_reg        <= used_plus2;
                            out_report_reg  <= 1'b0;
                            out_p0_reg      <= prev_reg;
                            out_p1_reg      <= cur;
                            out_color_reg   <= cmd_reg.rgba;
                            out_drawn_reg   <= '0;
                            out_dropped_reg <= '0;
                            out_last_reg    <= (k_reg == K_LAST) || !fit_two;
                        end
                        else
                        begin
                            dropped_reg <= dropped_plus2;
                        end
                        prev_reg   <= cur;
                        k_reg      <= k_reg + 1'b1;
                        idx_reg    <= idx_next;
                        rem_reg    <= rem_next;
                        prod_c_reg <= wcsg_pkg::PROD_W'(cmd_reg.radius)
                                    * wcsg_pkg::PROD_W'(wcsg_pkg::cos_mag(idx_mul));
                        prod_s_reg <= wcsg_pkg::PROD_W'(cmd_reg.radius)
                                    * wcsg_pkg::PROD_W'(wcsg_pkg::cos_mag(idx_mul_s));
                        neg_c_reg  <= wcsg_pkg::cos_neg(idx_mul);
                        neg_s_reg  <= wcsg_pkg::cos_neg(idx_mul_s);
                        if (k_reg == K_LAST)
                        begin
                            state_reg <= S_IDLE;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_report_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {3'b000, out_dropped_reg, out_drawn_reg, out_color_reg,
                       out_p1_reg[2], out_p1_reg[1], out_p1_reg[0],
                       out_p0_reg[2], out_p0_reg[1], out_p0_reg[0]};

    property p_budget;
        @(posedge clk) disable iff (!rst_n)
        {2'b00, used_reg} <= MAX_V;
    endproperty
    a_budget: assert property (p_budget)
        else $error("Vertex count exceeds the frame budget.");

    property p_report_last;
        @(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[0]) |-> m_tlast;
    endproperty
    a_report_last: assert property (p_report_last)
        else $error("End-of-frame word without the last mark.");

    property p_report_clears;
        @(posedge clk) disable iff (!rst_n)
        (accept && (cmd.op == wcsg_pkg::OP_REPORT)) |=> (used_reg == '0) && (dropped_reg == '0);
    endproperty
    a_report_clears: assert property (p_report_clears)
        else $error("Frame counts not cleared after a report.");

    property p_chord_range;
        @(posedge clk) disable iff (!rst_n)
        (state_reg == S_CHORD) |-> (k_reg != '0) && (k_reg <= K_LAST);
    endproperty
    a_chord_range: assert property (p_chord_range)
        else $error("Chord counter out of range.");

endmodule
